[rtl/plv_pkg.sv]
`default_nettype none

package plv_pkg;

    // default geometry
    localparam int NUM_WAYS_DEF  = 16;
    localparam int NUM_SETS_DEF  = 1024;
    localparam int TIME_BITS_DEF = 32;

    // queue depths
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACCEL_WAYS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL_WAYS = 1'd1;
    localparam logic [CFG_DATA_W-1:0] MIN_ACCEL_RESET = 5'd0;
    localparam logic [CFG_DATA_W-1:0] MAX_ACCEL_RESET = 5'd16;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  set_index;
        logic [3:0]  way;
        logic        requester_is_accel;
        logic [31:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       victim_valid;
    } out_item_t;

    // request type codes
    localparam logic REQ_TOUCH = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CMD_TOUCH = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_NULL  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [9:0]  set_index;
        logic [3:0]  way;
        logic        accel;
        logic [31:0] timestamp;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/partitioned_lru_victim_select.sv]
`default_nettype none

// Way-partitioned LRU victim selection. Requests enter as beats on a queue
// interface (push/full); touches record a way's time and owner class, victim
// queries return one result beat each on the result queue (empty/pop), in
// request order; touches produce no result. After reset the block sweeps its
// set memories clear, one set per cycle, over all NUM_SETS sets (1024 by
// default) with full held high; configuration writes are taken during the
// sweep. A query passes in order through the registered set-memory read, one
// register per level of the min/count tree over the ways, the registered
// victim decision and the push into the result queue; a query waits in the
// command queue while the result queue is full, and no command is taken
// while a query is in flight. Out-of-range touches are dropped at the front
// end and never reach the back end; out-of-range queries pass through the
// same back-end steps and return victim_valid = 0.

module partitioned_lru_victim_select
    import plv_pkg::*;
#(
    parameter int NUM_WAYS  = NUM_WAYS_DEF,
    parameter int NUM_SETS  = NUM_SETS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request side
    input  wire logic                  push,
    input  wire in_item_t              item,
    output logic                       full,
    // result side
    output logic                       empty,
    input  wire logic                  pop,
    output out_item_t                  result,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] min_accel_ways_reg, min_accel_ways_next;
    logic [CFG_DATA_W-1:0] max_accel_ways_reg, max_accel_ways_next;

    cmd_t      cmd;
    logic      cmd_empty;
    logic      cmd_pop;
    logic      clearing;
    logic      res_full;
    logic      res_push;
    out_item_t res_item;

    // partition limits
    always_comb
    begin
        min_accel_ways_next = min_accel_ways_reg;
        max_accel_ways_next = max_accel_ways_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_ACCEL_WAYS: min_accel_ways_next = cfg_data;
                CFG_MAX_ACCEL_WAYS: max_accel_ways_next = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_accel_ways_reg <= MIN_ACCEL_RESET;
            max_accel_ways_reg <= MAX_ACCEL_RESET;
        end
        else
        begin
            min_accel_ways_reg <= min_accel_ways_next;
            max_accel_ways_reg <= max_accel_ways_next;
        end
    end

    // front end: range checks, classification, command queue
    plv_front #(
        .NUM_WAYS (NUM_WAYS),
        .NUM_SETS (NUM_SETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .clearing  (clearing),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    // back end: set memories, way scan tree, victim rules
    plv_back #(
        .NUM_WAYS  (NUM_WAYS),
        .NUM_SETS  (NUM_SETS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cmd_empty      (cmd_empty),
        .cmd_pop        (cmd_pop),
        .clearing       (clearing),
        .min_accel_ways (min_accel_ways_reg),
        .max_accel_ways (max_accel_ways_reg),
        .res_full       (res_full),
        .res_push       (res_push),
        .res_item       (res_item)
    );

    // result queue; a query is not issued to the back end while it is full
    plv_fifo #(
        .T     (out_item_t),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_item),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

[rtl/plv_fifo.sv]
`default_nettype none

module plv_fifo
    import plv_pkg::*;
#(
    parameter type T     = cmd_t,
    parameter int  DEPTH = CMD_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     din,
    output logic      full,
    input  wire logic pop,
    output T          dout,
    output logic      empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (32'(count_reg) == DEPTH);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

[rtl/plv_front.sv]
`default_nettype none

module plv_front
    import plv_pkg::*;
#(
    parameter int NUM_WAYS = NUM_WAYS_DEF,
    parameter int NUM_SETS = NUM_SETS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_item_t item,
    output logic          full,
    input  wire logic     clearing,
    input  wire logic     cmd_pop,
    output cmd_t          cmd,
    output logic          cmd_empty
);

    cmd_t cmd_in;
    logic cmd_push;
    logic q_full;
    logic accept;
    logic set_ok;
    logic way_ok;

    // no beats taken during the clearing sweep
    assign full   = q_full || clearing;
    assign accept = push && !full;
    assign set_ok = 32'(item.set_index) < NUM_SETS;
    assign way_ok = 32'(item.way) < NUM_WAYS;

    always_comb
    begin
        cmd_in.set_index = item.set_index;
        cmd_in.way       = item.way;
        cmd_in.accel     = item.requester_is_accel;
        cmd_in.timestamp = item.timestamp;
        cmd_in.kind      = CMD_NULL;
        cmd_push         = accept;
        unique case (item.req_type)
            REQ_TOUCH:
            begin
                // out-of-range touches are dropped here
                cmd_in.kind = CMD_TOUCH;
                cmd_push    = accept && set_ok && way_ok;
            end
            REQ_QUERY:
            begin
                cmd_in.kind = set_ok ? CMD_QUERY : CMD_NULL;
            end
            default:
            begin
                cmd_push = 1'b0;
            end
        endcase
    end

    plv_fifo #(
        .T     (cmd_t),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (q_full),
        .pop   (cmd_pop),
        .dout  (cmd),
        .empty (cmd_empty)
    );

endmodule

`default_nettype wire

[rtl/plv_back.sv]
`default_nettype none

module plv_back
    import plv_pkg::*;
#(
    parameter int NUM_WAYS  = NUM_WAYS_DEF,
    parameter int NUM_SETS  = NUM_SETS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic                  cmd_empty,
    output logic                       cmd_pop,
    output logic                       clearing,
    input  wire logic [CFG_DATA_W-1:0] min_accel_ways,
    input  wire logic [CFG_DATA_W-1:0] max_accel_ways,
    input  wire logic                  res_full,
    output logic                       res_push,
    output out_item_t                  res_item
);

    localparam int SET_AW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int LEVELS   = WAY_W;
    localparam int LEAVES   = 1 << WAY_W;
    localparam int CNT_W    = $clog2(NUM_WAYS + 1);
    localparam int ROW_BITS = NUM_WAYS * TIME_BITS;
    localparam int PAD_BITS = LEAVES * TIME_BITS;

    typedef struct packed {
        logic                 have_acc;
        logic [TIME_BITS-1:0] acc_time;
        logic [WAY_W-1:0]     acc_way;
        logic                 have_cpu;
        logic [TIME_BITS-1:0] cpu_time;
        logic [WAY_W-1:0]     cpu_way;
        logic [CNT_W-1:0]     acc_count;
    } node_t;

    // lower half holds the lower ways, so it wins ties on time
    function automatic node_t merge(input node_t a, input node_t b);
        node_t r;
        r.have_acc  = a.have_acc || b.have_acc;
        r.have_cpu  = a.have_cpu || b.have_cpu;
        r.acc_count = a.acc_count + b.acc_count;
        if (a.have_acc && (!b.have_acc || a.acc_time <= b.acc_time))
        begin
            r.acc_time = a.acc_time;
            r.acc_way  = a.acc_way;
        end
        else
        begin
            r.acc_time = b.acc_time;
            r.acc_way  = b.acc_way;
        end
        if (a.have_cpu && (!b.have_cpu || a.cpu_time <= b.cpu_time))
        begin
            r.cpu_time = a.cpu_time;
            r.cpu_way  = a.cpu_way;
        end
        else
        begin
            r.cpu_time = b.cpu_time;
            r.cpu_way  = b.cpu_way;
        end
        return r;
    endfunction

    // set memories
    logic [ROW_BITS-1:0] time_mem [NUM_SETS];
    logic [NUM_WAYS-1:0] own_mem  [NUM_SETS];
    logic [ROW_BITS-1:0] rd_time_reg;
    logic [NUM_WAYS-1:0] rd_own_reg;

    logic              clearing_reg, clearing_next;
    logic [SET_AW-1:0] clr_addr_reg, clr_addr_next;

    logic [LEVELS:0]   vld_reg, vld_next;
    logic              null_reg, null_next;
    logic              accel_reg, accel_next;
    logic              res_valid_reg, res_valid_next;
    out_item_t         res_item_reg, res_item_next;

    logic              busy;
    logic              is_query;
    logic              touch_we;
    logic              issue;
    logic              rd_en;
    logic [SET_AW-1:0] mem_addr;
    logic [TIME_BITS-1:0] wr_time;

    logic [PAD_BITS-1:0] time_pad;
    logic [LEAVES-1:0]   own_pad;
    node_t               leaf     [LEAVES];
    node_t               lvl_reg  [LEVELS][LEAVES/2];
    node_t               root;

    assign clearing = clearing_reg;
    assign busy     = (|vld_reg) || res_valid_reg;
    assign is_query = (cmd.kind != CMD_TOUCH);
    assign cmd_pop  = !cmd_empty && !clearing_reg && !busy && (!is_query || !res_full);
    assign touch_we = cmd_pop && (cmd.kind == CMD_TOUCH);
    assign issue    = cmd_pop && is_query;
    assign rd_en    = cmd_pop && (cmd.kind == CMD_QUERY);
    assign mem_addr = SET_AW'(cmd.set_index);
    assign wr_time  = TIME_BITS'(cmd.timestamp);

    // clearing sweep, one set per cycle after reset
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (32'(clr_addr_reg) == NUM_SETS - 1)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            time_mem[clr_addr_reg] <= '0;
            own_mem[clr_addr_reg]  <= '0;
        end
        else if (touch_we)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (32'(cmd.way) == w)
                begin
                    time_mem[mem_addr][w*TIME_BITS +: TIME_BITS] <= wr_time;
                    own_mem[mem_addr][w]                         <= cmd.accel;
                end
            end
        end
        if (rd_en)
        begin
            rd_time_reg <= time_mem[mem_addr];
            rd_own_reg  <= own_mem[mem_addr];
        end
    end

    // leaves, padded to a power of two with empty ways
    assign time_pad = PAD_BITS'(rd_time_reg);
    assign own_pad  = LEAVES'(rd_own_reg);

    always_comb
    begin
        for (int j = 0; j < LEAVES; j++)
        begin
            leaf[j].have_acc  = own_pad[j] && (j < NUM_WAYS);
            leaf[j].have_cpu  = !own_pad[j] && (j < NUM_WAYS);
            leaf[j].acc_time  = time_pad[j*TIME_BITS +: TIME_BITS];
            leaf[j].cpu_time  = time_pad[j*TIME_BITS +: TIME_BITS];
            leaf[j].acc_way   = WAY_W'(j);
            leaf[j].cpu_way   = WAY_W'(j);
            leaf[j].acc_count = CNT_W'(own_pad[j] && (j < NUM_WAYS));
        end
    end

    // registered min tree, one level per cycle
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < LEAVES / 2; j++)
        begin
            lvl_reg[0][j] <= merge(leaf[2*j], leaf[2*j+1]);
        end
        for (int l = 1; l < LEVELS; l++)
        begin
            for (int j = 0; j < (LEAVES >> (l + 1)); j++)
            begin
                lvl_reg[l][j] <= merge(lvl_reg[l-1][2*j], lvl_reg[l-1][2*j+1]);
            end
        end
    end

    assign root = lvl_reg[LEVELS-1][0];

    // victim rules, in order
    always_comb
    begin
        vld_next       = {vld_reg[LEVELS-1:0], issue};
        null_next      = issue ? (cmd.kind == CMD_NULL) : null_reg;
        accel_next     = issue ? cmd.accel : accel_reg;
        res_valid_next = vld_reg[LEVELS];
        res_item_next  = res_item_reg;
        if (vld_reg[LEVELS])
        begin
            res_item_next.victim_valid = 1'b1;
            res_item_next.victim_way   = 4'(root.cpu_way);
            priority if (null_reg)
            begin
                res_item_next.victim_valid = 1'b0;
                res_item_next.victim_way   = '0;
            end
            else if ((32'(root.acc_count) > 32'(max_accel_ways)) && !accel_reg)
            begin
                res_item_next.victim_way = 4'(root.acc_way);
            end
            else if ((32'(root.acc_count) < 32'(min_accel_ways)) && accel_reg)
            begin
                if (!root.have_cpu)
                begin
                    res_item_next.victim_valid = 1'b0;
                    res_item_next.victim_way   = '0;
                end
            end
            else if (!root.have_acc)
            begin
                res_item_next.victim_way = 4'(root.cpu_way);
            end
            else if (!root.have_cpu || (root.cpu_time >= root.acc_time))
            begin
                res_item_next.victim_way = 4'(root.acc_way);
            end
            else
            begin
                res_item_next.victim_way = 4'(root.cpu_way);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            vld_reg       <= vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        null_reg     <= null_next;
        accel_reg    <= accel_next;
        res_item_reg <= res_item_next;
    end

    assign res_push = res_valid_reg;
    assign res_item = res_item_reg;

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !cmd_pop)
        else $error("command taken during clearing sweep");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({vld_reg, res_valid_reg}))
        else $error("more than one query in flight");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !res_full)
        else $error("result pushed into full queue");

    a_query_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> !res_full)
        else $error("query issued without result space");
`endif

endmodule

`default_nettype wire

[dv/plv_checker.sv]
`timescale 1ns / 1ps

module plv_checker
    import plv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire in_item_t              item,
    input  wire logic                  full,
    input  wire logic                  empty,
    input  wire logic                  pop,
    input  wire out_item_t             result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned                pending,
    output int unsigned                mismatches
);

    localparam int WAYS = NUM_WAYS_DEF;
    localparam int SETS = NUM_SETS_DEF;

    // shadow of the per-way time and owner class
    logic [31:0]           use_time    [SETS*WAYS];
    logic                  owner_accel [SETS*WAYS];
    logic [CFG_DATA_W-1:0] min_ways;
    logic [CFG_DATA_W-1:0] max_ways;
    out_item_t             victims_due [$];
    int unsigned           errors;

    function automatic out_item_t pick_victim(input logic [9:0] set_index,
                                              input logic accel_req);
        out_item_t   pick;
        logic [4:0]  n_accel;
        logic        seen_acc;
        logic        seen_cpu;
        logic        take_acc;
        logic [31:0] acc_t;
        logic [31:0] cpu_t;
        logic [31:0] t;
        logic [3:0]  acc_w;
        logic [3:0]  cpu_w;
        int          w;
        pick     = '0;
        n_accel  = '0;
        seen_acc = 1'b0;
        seen_cpu = 1'b0;
        acc_t    = '0;
        cpu_t    = '0;
        acc_w    = '0;
        cpu_w    = '0;
        for (w = 0; w < WAYS; w++)
        begin
            t = use_time[{set_index, w[3:0]}];
            if (owner_accel[{set_index, w[3:0]}])
            begin
                n_accel++;
                if (!seen_acc || t < acc_t)
                begin
                    seen_acc = 1'b1;
                    acc_t    = t;
                    acc_w    = w[3:0];
                end
            end
            else if (!seen_cpu || t < cpu_t)
            begin
                seen_cpu = 1'b1;
                cpu_t    = t;
                cpu_w    = w[3:0];
            end
        end
        if (n_accel > max_ways && !accel_req)
            take_acc = 1'b1;
        else if (n_accel < min_ways && accel_req)
        begin
            // accelerator below its floor with no cpu way to take
            if (!seen_cpu)
                return pick;
            take_acc = 1'b0;
        end
        else if (!seen_acc)
            take_acc = 1'b0;
        else if (!seen_cpu)
            take_acc = 1'b1;
        else
            take_acc = (cpu_t >= acc_t);
        pick.victim_way   = take_acc ? acc_w : cpu_w;
        pick.victim_valid = 1'b1;
        return pick;
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= 100)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        int        s;
        if (!rst_n)
        begin
            for (s = 0; s < SETS*WAYS; s++)
            begin
                use_time[s]    = '0;
                owner_accel[s] = 1'b0;
            end
            min_ways = MIN_ACCEL_RESET;
            max_ways = MAX_ACCEL_RESET;
            victims_due.delete();
            errors = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN_ACCEL_WAYS)
                    min_ways = cfg_data;
                else if (cfg_index == CFG_MAX_ACCEL_WAYS)
                    max_ways = cfg_data;
            end
            if (pop && !empty)
            begin
                if (victims_due.size() == 0)
                    report($sformatf("result beat way %0d valid %0d with none due",
                                     result.victim_way, result.victim_valid));
                else
                begin
                    want = victims_due.pop_front();
                    if (result.victim_valid !== want.victim_valid)
                        report($sformatf("victim_valid got %0d, expected %0d",
                                         result.victim_valid, want.victim_valid));
                    if (result.victim_way !== want.victim_way)
                        report($sformatf("victim_way got %0d, expected %0d",
                                         result.victim_way, want.victim_way));
                end
            end
            if (push && !full)
            begin
                if (item.req_type == REQ_TOUCH)
                begin
                    use_time[{item.set_index, item.way}]    = item.timestamp;
                    owner_accel[{item.set_index, item.way}] = item.requester_is_accel;
                end
                else
                    victims_due.push_back(pick_victim(item.set_index,
                                                      item.requester_is_accel));
            end
            pending    <= victims_due.size();
            mismatches <= errors;
        end
    end

endmodule

[dv/tb_partitioned_lru_victim_select.sv]
`timescale 1ns / 1ps

module tb_partitioned_lru_victim_select;
    import plv_pkg::*;

    // limit for the slowest legal run, including the clearing sweep
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 205;
    // drain time for a query in flight and both queues, with margin
    localparam int unsigned DRAIN_CYCLES = 24;
    // result count at which the receiver stops popping for a while
    localparam int unsigned HOLD_AT      = 25;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    in_item_t              item      = '0;
    logic                  full;
    logic                  empty;
    logic                  pop       = 1'b0;
    out_item_t             result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_ACCEL_WAYS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int unsigned           pending;
    int unsigned           mismatches;
    int unsigned           cycles    = 0;

    // sender and receiver pacing state
    bit                    tx_burst  = 1'b0;
    bit                    rx_burst  = 1'b0;
    int unsigned           rx_wait   = 0;
    int unsigned           rx_taken  = 0;
    logic [31:0]           tick      = '0;

    partitioned_lru_victim_select u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plv_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog: a hang or a lost result ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** partitioned_lru_victim_select: FAILED **");
            $finish;
        end
    end

    // result side: random stall before each pop, bursts with no stall,
    // and one long hold-off so the request side backs up and shows full
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop     <= 1'b0;
            rx_wait  = 0;
        end
        else if (pop && !empty)
        begin
            rx_taken++;
            if ($urandom_range(0, 47) == 0)
                rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
            if (rx_taken == HOLD_AT)
                rx_wait = HOLD_CYCLES;
            pop <= (rx_wait == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            pop <= (rx_wait == 0);
        end
        else
            pop <= 1'b1;
    end

    function automatic in_item_t beat(input logic kind, input logic [9:0] set_index,
                                      input logic [3:0] way, input logic accel,
                                      input logic [31:0] stamp);
        in_item_t b;
        b.req_type           = kind;
        b.set_index          = set_index;
        b.way                = way;
        b.requester_is_accel = accel;
        b.timestamp          = stamp;
        return b;
    endfunction

    // mix of wide random times, near-zero and near-max times (ties and
    // unsigned compare edges) and a rising clock like a real lru history
    function automatic logic [31:0] next_stamp();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default:
            begin
                tick += $urandom_range(1, 5);
                return tick;
            end
        endcase
    endfunction

    // offer one beat after a random gap; returns at the accepting edge
    // with push still high, so a back-to-back beat needs no toggle
    task automatic offer_beat(input in_item_t b);
        int unsigned gap;
        if ($urandom_range(0, 47) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    // stop sending and let every due result come back, then give the
    // back end time to finish any trailing touches
    task automatic wait_idle();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input logic [4:0] lo, input logic [4:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_ACCEL_WAYS;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_MAX_ACCEL_WAYS;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int unsigned ph;
        int unsigned sent;
        int unsigned n;
        int unsigned pct;
        int unsigned pick;
        int          w;
        logic [3:0]  start;
        logic [9:0]  target;
        logic [4:0]  lo;
        logic [4:0]  hi;
        logic [9:0]  hot_sets [4];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset defaults, field extremes, class ties
        // fresh set: all ways cpu-owned at time zero, lowest way wins
        offer_beat(beat(REQ_QUERY, 10'd0, 4'd0, 1'b0, 32'd0));
        offer_beat(beat(REQ_QUERY, 10'd0, 4'd15, 1'b1, 32'hFFFF_FFFF));
        offer_beat(beat(REQ_TOUCH, 10'd1023, 4'd15, 1'b1, 32'hFFFF_FFFF));
        offer_beat(beat(REQ_TOUCH, 10'd1023, 4'd0, 1'b1, 32'd0));
        // accel way 0 and cpu way 1 both at time zero: tie goes to accel
        offer_beat(beat(REQ_QUERY, 10'd1023, 4'd0, 1'b0, 32'd0));
        offer_beat(beat(REQ_QUERY, 10'd1023, 4'd0, 1'b1, 32'd0));
        offer_beat(beat(REQ_TOUCH, 10'd1023, 4'd0, 1'b0, 32'hFFFF_FFFF));
        offer_beat(beat(REQ_QUERY, 10'd1023, 4'd7, 1'b1, 32'd0));
        // msb-set vs msb-clear time, compare must be unsigned
        offer_beat(beat(REQ_TOUCH, 10'd512, 4'd7, 1'b1, 32'h8000_0000));
        offer_beat(beat(REQ_TOUCH, 10'd512, 4'd8, 1'b1, 32'h7FFF_FFFF));
        offer_beat(beat(REQ_QUERY, 10'd512, 4'd0, 1'b0, 32'd0));
        offer_beat(beat(REQ_QUERY, 10'd512, 4'd0, 1'b1, 32'd0));
        // every way of one set owned by the accelerator
        for (w = 0; w < 16; w++)
        begin
            offer_beat(beat(REQ_TOUCH, 10'd341, w[3:0], 1'b1, 32'd100 - w));
        end
        // then one cpu query and one accelerator query on that set
        offer_beat(beat(REQ_QUERY, 10'd341, 4'd0, 1'b0, 32'd0));
        offer_beat(beat(REQ_QUERY, 10'd341, 4'd0, 1'b1, 32'd0));

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            // limit pairs: defaults, both extremes, narrow windows, and
            // floors above the way count so the accelerator can starve
            case (ph)
                0: begin lo = 5'd0;  hi = 5'd16; end
                1: begin lo = 5'd0;  hi = 5'd0;  end
                2: begin lo = 5'd16; hi = 5'd16; end
                3: begin lo = 5'd4;  hi = 5'd12; end
                4: begin lo = 5'd8;  hi = 5'd8;  end
                5: begin lo = 5'd31; hi = 5'd16; end
                6: begin lo = 5'd17; hi = 5'd3;  end
                default: begin lo = 5'd2; hi = 5'd31; end
            endcase
            write_limits(lo, hi);

            // a few hot sets so histories build up across sequences
            hot_sets[0] = 10'd0;
            hot_sets[1] = 10'd1023;
            hot_sets[2] = 10'($urandom_range(0, 1023));
            hot_sets[3] = 10'($urandom_range(0, 1023));

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick   = $urandom_range(0, 99);
                target = hot_sets[$urandom_range(0, 3)];
                pct    = $urandom_range(0, 4) * 25;
                if (pick < 55)
                begin
                    // whole-set refill with a chosen accel share, then queries
                    start = 4'($urandom_range(0, 15));
                    for (w = 0; w < 16; w++)
                    begin
                        offer_beat(beat(REQ_TOUCH, target, start + w[3:0],
                                        $urandom_range(0, 99) < pct, next_stamp()));
                        sent++;
                    end
                    n = $urandom_range(1, 3);
                    repeat (n)
                    begin
                        offer_beat(beat(REQ_QUERY, target, 4'($urandom),
                                        1'($urandom_range(0, 1)), $urandom));
                        sent++;
                    end
                end
                else if (pick < 85)
                begin
                    // a few touches on an existing history, then one query
                    n = $urandom_range(1, 5);
                    repeat (n)
                    begin
                        offer_beat(beat(REQ_TOUCH, target, 4'($urandom_range(0, 15)),
                                        $urandom_range(0, 99) < pct, next_stamp()));
                        sent++;
                    end
                    offer_beat(beat(REQ_QUERY, target, 4'($urandom),
                                    1'($urandom_range(0, 1)), $urandom));
                    sent++;
                end
                else
                begin
                    // noise: any field, any set
                    offer_beat(beat(1'($urandom_range(0, 1)), 10'($urandom), 4'($urandom),
                                    1'($urandom_range(0, 1)), $urandom));
                    sent++;
                end
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("** partitioned_lru_victim_select: PASSED **");
        else
            $display("** partitioned_lru_victim_select: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/plv_pkg.sv
rtl/plv_fifo.sv
rtl/plv_front.sv
rtl/plv_back.sv
rtl/partitioned_lru_victim_select.sv
dv/plv_checker.sv
dv/tb_partitioned_lru_victim_select.sv
